// File: sv/mbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types, constants and the control store for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 64;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned WIDTH_W       = 7;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PEND_W        = BYTE_W - 1;
  localparam int unsigned CNT_W         = 3;
  localparam int unsigned STREAM_W      = VALUE_W + BYTE_W;
  localparam int unsigned NBYTE_W       = 4;
  localparam int unsigned STEP_W        = 4;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses
  localparam step_t ST_WAIT       = 4'd0;
  localparam step_t ST_DISPATCH   = 4'd1;
  localparam step_t ST_CHECK      = 4'd2;
  localparam step_t ST_MERGE      = 4'd3;
  localparam step_t ST_EMIT       = 4'd4;
  localparam step_t ST_COMMIT     = 4'd5;
  localparam step_t ST_FLUSH      = 4'd6;
  localparam step_t ST_FLUSH_EMIT = 4'd7;
  localparam step_t ST_ERR        = 4'd8;
  localparam step_t ST_LAST       = ST_ERR;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_ALIGN,
    DP_MERGE,
    DP_EMIT,
    DP_COMMIT,
    DP_FLUSH,
    DP_ERR
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_BEAT,
    C_FLUSH,
    C_BAD,
    C_NO_BYTES,
    C_LAST,
    C_PC_ZERO
  } cond_t;

  typedef struct packed {
    dp_op_t dp;
    cond_t  cond;
    logic   loop;      // stay on this step when the jump is not taken
    logic   wait_out;  // step needs a free output slot
    step_t  target;
  } ctrl_word_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic beat;
    logic flush;
    logic bad;
    logic no_bytes;
    logic last;
    logic pc_zero;
    logic out_free;
  } status_t;

  // Sequencer to datapath
  typedef struct packed {
    dp_op_t dp;
    logic   fire;
    logic   idle;
  } seq_ctrl_t;

  function automatic ctrl_word_t ucode_rom(input step_t addr);
    ctrl_word_t cw;
    cw = '{dp: DP_NOP, cond: C_ALWAYS, loop: 1'b0, wait_out: 1'b0, target: ST_WAIT};
    unique case (addr)
      ST_WAIT:       cw = '{DP_LOAD,   C_NO_BEAT,  1'b0, 1'b0, ST_WAIT};
      ST_DISPATCH:   cw = '{DP_NOP,    C_FLUSH,    1'b0, 1'b0, ST_FLUSH};
      ST_CHECK:      cw = '{DP_ALIGN,  C_BAD,      1'b0, 1'b0, ST_ERR};
      ST_MERGE:      cw = '{DP_MERGE,  C_NO_BYTES, 1'b0, 1'b0, ST_COMMIT};
      ST_EMIT:       cw = '{DP_EMIT,   C_LAST,     1'b1, 1'b1, ST_COMMIT};
      ST_COMMIT:     cw = '{DP_COMMIT, C_ALWAYS,   1'b0, 1'b0, ST_WAIT};
      ST_FLUSH:      cw = '{DP_NOP,    C_PC_ZERO,  1'b0, 1'b0, ST_WAIT};
      ST_FLUSH_EMIT: cw = '{DP_FLUSH,  C_ALWAYS,   1'b0, 1'b1, ST_WAIT};
      ST_ERR:        cw = '{DP_ERR,    C_ALWAYS,   1'b0, 1'b1, ST_WAIT};
      default:       cw = '{DP_NOP,    C_ALWAYS,   1'b0, 1'b0, ST_WAIT};
    endcase
    return cw;
  endfunction

endpackage

// File: sv/mbp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module mbp_seq import mbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  status_t   st,
  output seq_ctrl_t ctrl
);

  step_t      upc_r;
  step_t      upc_nxt;
  ctrl_word_t cw;
  logic       stall;
  logic       take;

  assign cw    = ucode_rom(upc_r);
  assign stall = cw.wait_out && !st.out_free;

  always_comb begin
    unique case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_BEAT:  take = !st.beat;
      C_FLUSH:    take = st.flush;
      C_BAD:      take = st.bad;
      C_NO_BYTES: take = st.no_bytes;
      C_LAST:     take = st.last;
      C_PC_ZERO:  take = st.pc_zero;
      default:    take = 1'b1;
    endcase
  end

  always_comb begin
    priority if (stall) begin
      upc_nxt = upc_r;
    end else if (take) begin
      upc_nxt = cw.target;
    end else if (cw.loop) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl.dp   = cw.dp;
  assign ctrl.fire = !stall;
  assign ctrl.idle = (upc_r == ST_WAIT);

`ifndef SYNTHESIS
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= ST_LAST)
    else $error("step counter outside program");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(upc_r))
    else $error("step advanced while output slot busy");

  a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == ST_WAIT && !st.beat) |=> upc_r == ST_WAIT)
    else $error("left wait step without a beat");
`endif

endmodule

// File: sv/msb_first_bit_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// Variable-width MSB-first bit writer producing a byte stream.
// ----------------------------------------------------------------------------
// A write beat (op 0) appends the low in_width bits of in_value, MSB first,
// behind up to seven pending bits; every full byte leaves on the out channel
// with the earliest bit in bit 7, and out_is_last marks the final byte of the
// beat. A write that completes no byte gives no output. Width 0, width above
// MAX_WIDTH, or a value with bits set at or above its width gives one beat
// with out_error = 1, out_byte = 0, and leaves the pending bits alone. A flush
// beat (op 1) pads pending bits with zeros, emits that byte and clears them;
// with nothing pending it emits nothing. Items are processed one at a time by
// a microcoded sequencer: a write runs dispatch, check, merge, an emit step
// per completed byte (0..8) and commit, emit steps waiting for a free output
// slot; an error runs dispatch, check and error; a flush dispatch, flush and,
// with bits pending, flush-emit. The single byte-wide output port, one byte
// per cycle while out_ready is high, sets the per-byte pace. The output
// register lets the next item in while the last byte waits for out_ready.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core import mbp_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [WIDTH_W-1:0] in_width,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_is_last,
  output logic               out_error
);

  // Item registers
  logic                op_r;
  logic [VALUE_W-1:0]  value_r;
  logic [WIDTH_W-1:0]  width_r;

  // Pending bits, kept left aligned; bits below the count are zero
  logic [PEND_W-1:0]   pend_r;
  logic [CNT_W-1:0]    pc_r;

  // Bit stream window, earliest bit at the top
  logic [STREAM_W-1:0] s_r;
  logic [NBYTE_W-1:0]  n_r;

  // Output register
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_last_r;
  logic                out_err_r;

  seq_ctrl_t           ctrl;
  status_t             st;
  logic                beat;
  logic                out_free;
  logic [WIDTH_W-1:0]  sum;
  logic [WIDTH_W-1:0]  align_sh;
  logic                bad;
  logic                emit;

  assign in_ready = ctrl.idle;
  assign beat     = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Total stream length pc + width fits in 7 bits for legal widths
  assign sum      = WIDTH_W'(pc_r) + width_r;
  assign align_sh = WIDTH_W'(VALUE_W) - width_r;

  assign bad = (width_r == '0) || (width_r > WIDTH_W'(MAX_WIDTH)) ||
               ((value_r >> width_r) != '0);

  assign st.beat     = beat;
  assign st.flush    = op_r;
  assign st.bad      = bad;
  assign st.no_bytes = (sum[WIDTH_W-1:CNT_W] == '0);
  assign st.last     = (n_r == NBYTE_W'(1));
  assign st.pc_zero  = (pc_r == '0);
  assign st.out_free = out_free;

  mbp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctrl  (ctrl)
  );

  assign emit = ctrl.fire &&
                (ctrl.dp == DP_EMIT || ctrl.dp == DP_FLUSH || ctrl.dp == DP_ERR);

  // Item capture and stream window
  always_ff @(posedge clk) begin
    if (ctrl.dp == DP_LOAD && beat) begin
      op_r    <= in_op;
      value_r <= in_value;
      width_r <= in_width;
    end
    if (ctrl.fire) begin
      unique case (ctrl.dp)
        DP_ALIGN: s_r <= {value_r << align_sh, {BYTE_W{1'b0}}};
        DP_MERGE: s_r <= {pend_r, {(STREAM_W-PEND_W){1'b0}}} | (s_r >> pc_r);
        DP_EMIT:  s_r <= s_r << BYTE_W;
        default:  s_r <= s_r;
      endcase
    end
  end

  // Pending state and byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pc_r   <= '0;
      n_r    <= '0;
    end else if (ctrl.fire) begin
      unique case (ctrl.dp)
        DP_MERGE: n_r <= NBYTE_W'(sum[WIDTH_W-1:CNT_W]);
        DP_EMIT:  n_r <= n_r - NBYTE_W'(1);
        DP_COMMIT: begin
          pend_r <= s_r[STREAM_W-1 -: PEND_W];
          pc_r   <= sum[CNT_W-1:0];
        end
        DP_FLUSH: begin
          pend_r <= '0;
          pc_r   <= '0;
        end
        default: begin
          n_r <= n_r;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (ctrl.dp)
        DP_EMIT: begin
          out_byte_r <= s_r[STREAM_W-1 -: BYTE_W];
          out_last_r <= (n_r == NBYTE_W'(1));
          out_err_r  <= 1'b0;
        end
        DP_FLUSH: begin
          out_byte_r <= {pend_r, 1'b0};
          out_last_r <= 1'b1;
          out_err_r  <= 1'b0;
        end
        default: begin
          out_byte_r <= '0;
          out_last_r <= 1'b1;
          out_err_r  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_last_r;
  assign out_error   = out_err_r;

`ifndef SYNTHESIS
  a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r << pc_r) == '0)
    else $error("pending bits below the count are not zero");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fire && ctrl.dp == DP_EMIT) |-> (n_r != '0 && n_r <= NBYTE_W'(BYTE_W)))
    else $error("byte emitted with no completed byte");

  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_byte_r == '0 && out_last_r))
    else $error("error beat carries data or is not last");
`endif

endmodule

// File: test/msb_first_bit_packer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core_tb
// Self-checking bench for the MSB-first bit packer. Write and flush beats go
// in on the in_ channel. A bit-level model of the packer predicts every byte
// that should come out, and each out_ beat is checked against the oldest
// predicted byte. The run starts with corner beats, then goes to a long mixed
// random stream, a pause that lets the packer empty, and a tail with no
// throttling on either side.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core_tb import mbp_pkg::*; ();

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int unsigned MAX_W = MAX_WIDTH_DEF;

  // The longest stretch with no handshake, a beat inside the packer plus a
  // random gap on each side, is still far below this count.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles to watch after the last byte, so that a stray extra byte gets caught.
  localparam int END_TAIL = 32;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              err;
  } packed_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_op = OP_WRITE;
  logic [VALUE_W-1:0] in_value = '0;
  logic [WIDTH_W-1:0] in_width = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_is_last;
  logic               out_error;

  // Model state: bits not yet part of a full byte, newest bit in bit 0.
  logic [PEND_W-1:0] held_bits = '0;
  logic [CNT_W-1:0]  held_count = '0;

  packed_byte_t bytes_due[$];
  int           fail_count = 0;
  int           quiet_cycles = 0;
  bit           throttle_on = 1'b1;

  always #6 clk = ~clk;

  msb_first_bit_packer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_value   (in_value),
    .in_width   (in_width),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_is_last(out_is_last),
    .out_error  (out_error)
  );

  // --------------------------------------------------------------------------
  // Bit-level model. For each accepted beat, push the bytes it should produce.
  // --------------------------------------------------------------------------
  function automatic void pack_into_bytes(input logic op, input logic [VALUE_W-1:0] value,
                                          input logic [WIDTH_W-1:0] width);
    logic [BYTE_W-1:0] acc;
    int                cnt;
    int                made;
    packed_byte_t      b;
    // Flush: pad the held bits with zeros on the right. With nothing held
    // it produces no byte.
    if (op == OP_FLUSH) begin
      if (held_count != 0) begin
        b.data = BYTE_W'(held_bits) << (BYTE_W - held_count);
        b.last = 1'b1;
        b.err  = 1'b0;
        bytes_due.push_back(b);
        held_bits  = '0;
        held_count = '0;
      end
      return;
    end
    // Rejected write: one zero byte with the error flag set. The held
    // bits are left as they are.
    if (width == 0 || width > MAX_W || (width < VALUE_W && (value >> width) != 0)) begin
      b.data = '0;
      b.last = 1'b1;
      b.err  = 1'b1;
      bytes_due.push_back(b);
      return;
    end
    acc  = BYTE_W'(held_bits);
    cnt  = held_count;
    made = 0;
    for (int i = int'(width) - 1; i >= 0; i--) begin
      acc = {acc[BYTE_W-2:0], value[i]};
      cnt++;
      if (cnt == BYTE_W) begin
        b.data = acc;
        b.last = 1'b0;
        b.err  = 1'b0;
        bytes_due.push_back(b);
        made++;
        acc = '0;
        cnt = 0;
      end
    end
    // Only the final byte of the beat carries last.
    if (made > 0)
      bytes_due[bytes_due.size()-1].last = 1'b1;
    held_bits  = acc[PEND_W-1:0];
    held_count = CNT_W'(cnt);
  endfunction

  // --------------------------------------------------------------------------
  // Source side. The task returns in the same time step as the accepting
  // edge, so the next beat can keep in_valid high. in_valid only drops when
  // a gap is taken or when the caller waits for the packer to empty.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic op, input logic [VALUE_W-1:0] value,
                           input logic [WIDTH_W-1:0] width);
    int gap;
    if (throttle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= value;
    in_width <= width;
    do @(posedge clk); while (!in_ready);
    pack_into_bytes(op, value, width);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (bytes_due.size() != 0);
  endtask

  // Sink side: random stall bursts. The gaps between bursts give
  // stretches with no stall.
  initial begin : sink_pacing
    int gap;
    forever begin
      @(posedge clk);
      if (throttle_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 18);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Output checker. Compares each accepted byte with the oldest predicted one.
  always @(posedge clk) begin : byte_check
    packed_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat byte=%02h last=%0b error=%0b",
                 $time, out_byte, out_is_last, out_error);
      end else begin
        want = bytes_due.pop_front();
        if (out_byte !== want.data) begin
          fail_count++;
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
        end
        if (out_is_last !== want.last) begin
          fail_count++;
          $display("%0t: out_is_last expected %0b actual %0b", $time, want.last, out_is_last);
        end
        if (out_error !== want.err) begin
          fail_count++;
          $display("%0t: out_error expected %0b actual %0b", $time, want.err, out_error);
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel completes a handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d bytes outstanding", $time, bytes_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner beats: smallest and largest width, all-ones and all-zero values,
  // each reject path, a flush with and without held bits, a flush with junk
  // in its operands, and writes that complete no byte or exactly one byte.
  task automatic test_corner_beats();
    send_beat(OP_WRITE, 64'd1, 7'd1);
    send_beat(OP_WRITE, 64'd0, 7'd1);
    send_beat(OP_FLUSH, 64'd0, 7'd0);                    // pads two bits -> 0x80
    send_beat(OP_FLUSH, 64'd0, 7'd0);                    // nothing held, no byte
    send_beat(OP_WRITE, '1, 7'd64);
    send_beat(OP_WRITE, 64'd0, 7'd64);
    send_beat(OP_WRITE, 64'hA5, 7'd8);
    send_beat(OP_WRITE, 64'd5, 7'd3);                    // no byte, three held
    send_beat(OP_WRITE, 64'h0123_4567_89AB_CDEF, 7'd64); // crosses byte bounds
    send_beat(OP_WRITE, 64'd0, 7'd0);                    // zero width
    send_beat(OP_WRITE, 64'd1, 7'd65);                   // just past the max
    send_beat(OP_WRITE, '1, 7'h7F);                      // every width bit set
    send_beat(OP_WRITE, 64'h10, 7'd4);                   // value too wide
    send_beat(OP_WRITE, 64'h8000_0000_0000_0000, 7'd63);
    send_beat(OP_WRITE, 64'd2, 7'd1);
    send_beat(OP_WRITE, 64'h7FFF_FFFF_FFFF_FFFF, 7'd63);
    send_beat(OP_FLUSH, '1, 7'h7F);                      // operands ignored
    send_beat(OP_WRITE, 64'h1F, 7'd5);
    send_beat(OP_WRITE, 64'd0, 7'd3);                    // lands on a byte edge
    send_beat(OP_FLUSH, 64'd0, 7'd0);
    send_beat(OP_WRITE, 64'h7F, 7'd7);
    send_beat(OP_WRITE, 64'd1, 7'd1);                    // -> 0xFF
    send_beat(OP_WRITE, 64'h55, 7'd7);
    send_beat(OP_FLUSH, 64'd0, 7'd0);
  endtask

  // One random beat. Most are legal writes, many of them narrow, so that
  // byte boundaries fall at every offset. The rest are flushes and rejects.
  task automatic send_random_beat();
    logic [VALUE_W-1:0] v;
    logic [WIDTH_W-1:0] w;
    int                 pick;
    pick = $urandom_range(0, 99);
    w = WIDTH_W'($urandom_range(1, MAX_W));
    if ($urandom_range(0, 2) == 0)
      w = WIDTH_W'($urandom_range(1, 12));
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '1;
      1: v = '0;
      default: ;
    endcase
    if (w < VALUE_W)
      v &= (64'd1 << w) - 64'd1;
    if (pick < 10)
      send_beat(OP_FLUSH, {$urandom, $urandom}, WIDTH_W'($urandom));
    else if (pick < 14)
      send_beat(OP_WRITE, v, '0);
    else if (pick < 18)
      send_beat(OP_WRITE, v, WIDTH_W'($urandom_range(MAX_W + 1, 127)));
    else if (pick < 23) begin
      // force one bit at or above the width
      w = WIDTH_W'($urandom_range(1, VALUE_W - 1));
      v |= 64'd1 << $urandom_range(w, VALUE_W - 1);
      send_beat(OP_WRITE, v, w);
    end else
      send_beat(OP_WRITE, v, w);
  endtask

  task automatic test_random_stream(input int n_beats);
    for (int i = 0; i < n_beats; i++) begin
      if ($urandom_range(0, 19) == 0)
        throttle_on = ~throttle_on;
      send_random_beat();
    end
    throttle_on = 1'b1;
  endtask

  // The source holds off until every predicted byte has come out, then
  // sends more beats on top of the held bits.
  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++)
      send_random_beat();
    wait_until_drained();
    for (int i = 0; i < 6; i++)
      send_random_beat();
  endtask

  // Neither side stalls here, so the packer runs at its full rate.
  task automatic test_unthrottled_tail();
    throttle_on = 1'b0;
    for (int i = 0; i < 20; i++)
      send_random_beat();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_beats();
    test_random_stream(140);
    test_drain_pause();
    test_unthrottled_tail();
    wait_until_drained();
    repeat (END_TAIL) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
